// ===== sv/cuns_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the control-unit next-state sequencer
// no dependencies

package cuns_pkg;

    localparam int STATE_W  = 6;
    localparam int OPCODE_W = 8;
    localparam int KEY_W    = STATE_W + OPCODE_W + 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    localparam logic [STATE_W-1:0] FETCH_STATE = '0;

    typedef logic [STATE_W-1:0] state_code_t;
    typedef logic [KEY_W-1:0]   seq_key_t;

    // lookup outcome from the sequencing table
    typedef struct packed {
        logic        hit;
        state_code_t next;
    } cuns_match_t;

endpackage

// ===== sv/control_unit_next_state.sv =====
`timescale 1ns / 1ps
// top level of the control-unit next-state sequencer
// depends on cuns_pkg and cuns_match
//
// usage
//   input stream (s_*): one transfer per control step, carrying the opcode and
//   the alu zero and carry flags. output stream (m_*): one transfer per input
//   transfer, carrying the new state code and whether a table row matched.
//   the state register starts at the fetch start state (zero) after reset and
//   is updated as each step leaves the input register for the result register.
// pipeline and throughput
//   an accepted transfer passes through the input register, then the result
//   register, to m_tdata; one transfer per cycle is sustained while m_tready
//   is high, with a combinational table match feeding the result and state registers.
// reset
//   rst_n clears the state register and both valid flags asynchronously.
// stall
//   when m_tready is low the result register holds; the input register still
//   takes one transfer, then s_tready falls until the result is taken.

module control_unit_next_state
    import cuns_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // opcode[7:0], zero_flag[8], carry_flag[9], zero fill
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // next_state[5:0], row_matched[6], zero fill
);

    // input register
    logic                in_valid_reg;
    logic [OPCODE_W-1:0] opcode_reg;
    logic                zero_flag_reg;
    logic                carry_flag_reg;

    // state and result register
    state_code_t state_reg;
    logic        out_valid_reg;
    state_code_t out_next_state_reg;
    logic        out_row_matched_reg;

    logic        advance;
    seq_key_t    key;
    cuns_match_t match;

    // result register is free when empty or being taken this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    assign key = {state_reg, opcode_reg, zero_flag_reg, carry_flag_reg};

    cuns_match u_match
    (
        .key    (key),
        .result (match)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload of the input register
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            opcode_reg     <= s_tdata[OPCODE_W-1:0];
            zero_flag_reg  <= s_tdata[OPCODE_W];
            carry_flag_reg <= s_tdata[OPCODE_W+1];
        end
    end

    // state advances exactly once per step, together with the result load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FETCH_STATE;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                state_reg <= match.next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_next_state_reg  <= match.next;
            out_row_matched_reg <= match.hit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_row_matched_reg, out_next_state_reg};

`ifndef NO_ASSERTIONS
    // the reported state is the one now held for the next step
    a_state_tracks_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg) |=> (state_reg == out_next_state_reg))
        else $error("state register differs from reported next state");

    // a miss always falls back to the fetch start state
    a_miss_goes_to_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_row_matched_reg) |-> (out_next_state_reg == FETCH_STATE))
        else $error("unmatched step did not return to fetch state");

    // no step moved, so the state holds
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && in_valid_reg) |=> $stable(state_reg))
        else $error("state changed without a step");

    // an empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");
`endif

endmodule

// ===== sv/cuns_match.sv =====
`timescale 1ns / 1ps
// first-match lookup of the sequencing table
// depends on cuns_pkg

module cuns_match
    import cuns_pkg::*;
(
    input  seq_key_t    key,    // state, opcode c7..c0, zero, carry; msb first
    output cuns_match_t result
);

    // earlier arms take priority over later ones
    always_comb
    begin
        result.hit  = 1'b1;
        result.next = FETCH_STATE;
        casez (key)
            16'b000000??????????: result.next = 6'b000001;
            16'b00000100????????: result.next = 6'b000010;
            16'b0000010100??????: result.next = 6'b001100;
            16'b0000010110??????: result.next = 6'b001111;
            16'b00000110?1??????: result.next = 6'b010101;
            16'b000001011100????: result.next = 6'b010000;
            16'b00000111000011??: result.next = 6'b010000;
            16'b00000111000100??: result.next = 6'b010000;
            16'b00000101110100??: result.next = 6'b010000;
            16'b00000110000000??: result.next = 6'b001110;
            16'b00000110000001??: result.next = 6'b010111;
            16'b00000110000010??: result.next = 6'b011000;
            16'b00000111000001??: result.next = 6'b011010;
            16'b00000111000101??: result.next = 6'b100000;
            16'b00000111000000??: result.next = 6'b100000;
            16'b00000111000010??: result.next = 6'b100101;
            16'b000010??00??????: result.next = 6'b000011;
            16'b000010??0100????: result.next = 6'b000100;
            16'b000010??0110????: result.next = 6'b000110;
            16'b000010??0111????: result.next = 6'b000111;
            16'b000010??1000????: result.next = 6'b001001;
            16'b000010??1001????: result.next = 6'b001010;
            16'b000010??1010????: result.next = 6'b001011;
            16'b000010??1011????: result.next = 6'b001000;
            16'b000010??11??????: result.next = 6'b000101;
            16'b000011??????????: result.next = 6'b000000;
            16'b000100??????????: result.next = 6'b000000;
            16'b000101??????????: result.next = 6'b000000;
            16'b000110??????????: result.next = 6'b000000;
            16'b000111??????????: result.next = 6'b000000;
            16'b001000??????????: result.next = 6'b000000;
            16'b001001??????????: result.next = 6'b000000;
            16'b001010??????????: result.next = 6'b000000;
            16'b001011??????????: result.next = 6'b000000;
            16'b001100???000????: result.next = 6'b101100;
            16'b001100???00100??: result.next = 6'b000100;
            16'b001100???00101??: result.next = 6'b000101;
            16'b001100???00110??: result.next = 6'b000110;
            16'b001100???00111??: result.next = 6'b000111;
            16'b001100???01?00??: result.next = 6'b001001;
            16'b001100???01?01??: result.next = 6'b001010;
            16'b001100???01?10??: result.next = 6'b001011;
            16'b001100???01?11??: result.next = 6'b001101;
            16'b001100???1??????: result.next = 6'b010011;
            16'b001101??????????: result.next = 6'b000000;
            16'b001110??????????: result.next = 6'b000000;
            16'b001111011000????: result.next = 6'b100111;
            16'b001111????0100??: result.next = 6'b000100;
            16'b001111????0101??: result.next = 6'b000101;
            16'b001111????0110??: result.next = 6'b000110;
            16'b001111????0111??: result.next = 6'b000111;
            16'b001111????1?00??: result.next = 6'b001001;
            16'b001111????1?01??: result.next = 6'b001010;
            16'b001111????1?10??: result.next = 6'b001011;
            16'b010000??????????: result.next = 6'b010001;
            16'b010001?????000??: result.next = 6'b010010;
            16'b010001?????001??: result.next = 6'b001100;
            16'b010001011100101?: result.next = 6'b010100;
            16'b01000101110011?1: result.next = 6'b010100;
            16'b01000101110100??: result.next = 6'b010100;
            16'b01000111000011??: result.next = 6'b100110;
            16'b01000111000100??: result.next = 6'b011010;
            16'b010001?????0100?: result.next = 6'b000000;
            16'b010001?????011?0: result.next = 6'b000000;
            16'b010010??????????: result.next = 6'b000100;
            16'b010011??????????: result.next = 6'b000000;
            16'b010100??????????: result.next = 6'b000000;
            16'b010101??????????: result.next = 6'b010110;
            16'b010110??0???????: result.next = 6'b001100;
            16'b010110??1???????: result.next = 6'b010010;
            16'b010111??????????: result.next = 6'b000000;
            16'b011000??????????: result.next = 6'b000000;
            16'b01100111000110??: result.next = 6'b011010;
            16'b01101011000001??: result.next = 6'b100100;
            16'b01101011000100??: result.next = 6'b011100;
            16'b01101011000110??: result.next = 6'b011101;
            16'b01110111000110??: result.next = 6'b101000;
            16'b01110011000100??: result.next = 6'b101000;
            16'b01110011000110??: result.next = 6'b101010;
            16'b01110111000100??: result.next = 6'b010100;
            16'b01111011000110??: result.next = 6'b000000;
            16'b01111111000101??: result.next = 6'b100001;
            16'b01111111000000??: result.next = 6'b100001;
            16'b10000011000101??: result.next = 6'b011111;
            16'b10000011000000??: result.next = 6'b011111;
            16'b10000111000101??: result.next = 6'b101001;
            16'b10000111000000??: result.next = 6'b101001;
            16'b10001011000000??: result.next = 6'b101011;
            16'b10001111000000??: result.next = 6'b000000;
            16'b10010011000001??: result.next = 6'b000000;
            16'b10010111000010??: result.next = 6'b011111;
            16'b10011011000011??: result.next = 6'b000000;
            16'b10100011000100??: result.next = 6'b011101;
            16'b10100011000110??: result.next = 6'b011100;
            16'b10100111000101??: result.next = 6'b000000;
            16'b10100111000000??: result.next = 6'b100010;
            16'b10101011000110??: result.next = 6'b011101;
            16'b10101111000000??: result.next = 6'b100011;
            16'b101100???000????: result.next = 6'b000000;
            default:
            begin
                result.hit  = 1'b0;
                result.next = FETCH_STATE;
            end
        endcase
    end

endmodule
